### src/fasta_record_stream_parser_core_assert.svh
// assertion macros for the fasta record stream parser
// expects clk and arst_n in the scope of the module that uses them
`ifndef FASTA_RECORD_STREAM_PARSER_CORE_ASSERT_SVH
`define FASTA_RECORD_STREAM_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FRSP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define FRSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/frsp_pkg.sv
// types and constants of the fasta record stream parser
// used by every module of the block, depends on nothing
`default_nettype none

package frsp_pkg;

	localparam int OUT_W = 32;

	localparam logic [7:0] CHAR_MARK = 8'h3E;
	localparam logic [7:0] CHAR_LF   = 8'h0A;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_END   = 2'd1,
		OP_WRITE = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ACT_STRIP   = 3'd0,
		ACT_KEEP    = 3'd1,
		ACT_FATAL   = 3'd2,
		ACT_SILENT  = 3'd3,
		ACT_NEWLINE = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		PH_EXPECT    = 3'd0,
		PH_HEADER    = 3'd1,
		PH_SEQ_START = 3'd2,
		PH_SEQ_MID   = 3'd3,
		PH_ENDED     = 3'd4,
		PH_HALTED    = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_HEADER = 3'd0,
		K_SEQ    = 3'd1,
		K_END    = 3'd2,
		K_ERROR  = 3'd3,
		K_DONE   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_NO_MARK  = 2'd1,
		ERR_HDR_OPEN = 2'd2,
		ERR_ILLEGAL  = 2'd3
	} err_t;

	// one input transaction plus its table lookup
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [2:0] action;
		logic [7:0] mapping;
	} item_t;

	// one result transaction
	typedef struct packed {
		kind_t            kind;
		logic [7:0]       value;
		err_t             error_code;
		logic [7:0]       offending_byte;
		logic [OUT_W-1:0] line_number;
		logic [OUT_W-1:0] record_number;
		logic [OUT_W-1:0] sequence_length;
		logic [OUT_W-1:0] stripped_total;
		logic             input_finished;
	} res_t;

	// handshake between the input stage and the engine
	typedef struct packed {
		logic s1_valid;
		logic out_free;
	} stage_ctl_t;

endpackage

`default_nettype wire

### src/frsp_table.sv
// 256-entry action and mapping table, one write and one registered read
// depends on frsp_pkg
`default_nettype none

module frsp_table
	import frsp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       we,
	input  wire logic [7:0] waddr,
	input  wire logic [2:0] wr_action,
	input  wire logic [7:0] wr_mapping,
	input  wire logic       re,
	input  wire logic [7:0] raddr,
	output logic [2:0]      rd_action,
	output logic [7:0]      rd_mapping
);

	logic [10:0] mem [256];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wr_action, wr_mapping};
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			{rd_action, rd_mapping} <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/frsp_engine.sv
// parser phase machine, saturating counters and result register
// depends on frsp_pkg and the assertion macro header
`default_nettype none

module frsp_engine
	import frsp_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire item_t      item_s1,
	input  wire logic       s1_valid,
	input  wire logic       out_ready,
	output stage_ctl_t      ctl,
	output logic            out_valid,
	output res_t            res
);

	localparam int ExtW = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

	phase_t phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] line_q, rec_q, kept_q, strip_q;
	logic [COUNT_WIDTH-1:0] line_inc, rec_inc, kept_inc, strip_inc;
	logic [ExtW-1:0] line_ext, rec_ext, kept_ext, strip_ext;
	logic fire, out_valid_q;
	logic emit, inc_line, inc_rec, inc_kept, inc_strip, clr_kept;
	res_t res_d, res_q;
	act_t act;

	assign fire = s1_valid & (~out_valid_q | out_ready);
	assign ctl.s1_valid = s1_valid;
	assign ctl.out_free = ~out_valid_q | out_ready;
	assign act = act_t'(item_s1.action);

	assign line_inc  = line_q + COUNT_WIDTH'(line_q != '1);
	assign rec_inc   = rec_q + COUNT_WIDTH'(rec_q != '1);
	assign kept_inc  = kept_q + COUNT_WIDTH'(kept_q != '1);
	assign strip_inc = strip_q + COUNT_WIDTH'(strip_q != '1);

	assign line_ext  = ExtW'(line_q);
	assign rec_ext   = ExtW'(inc_rec ? rec_inc : rec_q);
	assign kept_ext  = ExtW'(kept_q);
	assign strip_ext = ExtW'(strip_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (item_s1.op == OP_END) begin
			unique case (phase_q)
				PH_EXPECT, PH_ENDED, PH_SEQ_START, PH_SEQ_MID: phase_d = PH_ENDED;
				PH_HEADER: phase_d = PH_HALTED;
				default: phase_d = phase_q;
			endcase
		end else if (item_s1.op == OP_BYTE) begin
			unique case (phase_q)
				PH_EXPECT: phase_d = (item_s1.data == CHAR_MARK) ? PH_HEADER : PH_HALTED;
				PH_HEADER: phase_d = (item_s1.data == CHAR_LF) ? PH_SEQ_START : PH_HEADER;
				PH_SEQ_START, PH_SEQ_MID: begin
					if (phase_q == PH_SEQ_START && item_s1.data == CHAR_MARK) begin
						phase_d = PH_HEADER;
					end else if (act == ACT_FATAL) begin
						phase_d = PH_HALTED;
					end else begin
						phase_d = (item_s1.data == CHAR_LF) ? PH_SEQ_START : PH_SEQ_MID;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// result and counter updates
	always_comb begin
		emit      = 1'b0;
		inc_line  = 1'b0;
		inc_rec   = 1'b0;
		inc_kept  = 1'b0;
		inc_strip = 1'b0;
		clr_kept  = 1'b0;
		res_d.kind            = K_HEADER;
		res_d.value           = '0;
		res_d.error_code      = ERR_NONE;
		res_d.offending_byte  = '0;
		res_d.sequence_length = '0;
		res_d.input_finished  = 1'b0;
		if (item_s1.op == OP_END) begin
			unique case (phase_q)
				PH_EXPECT, PH_ENDED: begin
					emit = 1'b1;
					res_d.kind = K_DONE;
				end
				PH_HEADER: begin
					emit = 1'b1;
					res_d.kind = K_ERROR;
					res_d.error_code = ERR_HDR_OPEN;
				end
				PH_SEQ_START, PH_SEQ_MID: begin
					emit = 1'b1;
					inc_rec = 1'b1;
					clr_kept = 1'b1;
					res_d.kind = K_END;
					res_d.sequence_length = kept_ext[OUT_W-1:0];
					res_d.input_finished = 1'b1;
				end
				default: emit = 1'b0;
			endcase
		end else if (item_s1.op == OP_BYTE) begin
			unique case (phase_q)
				PH_EXPECT: begin
					if (item_s1.data != CHAR_MARK) begin
						emit = 1'b1;
						res_d.kind = K_ERROR;
						res_d.error_code = ERR_NO_MARK;
					end
				end
				PH_HEADER: begin
					if (item_s1.data == CHAR_LF) begin
						inc_line = 1'b1;
					end else begin
						emit = 1'b1;
						res_d.kind = K_HEADER;
						res_d.value = item_s1.data;
					end
				end
				PH_SEQ_START, PH_SEQ_MID: begin
					if (phase_q == PH_SEQ_START && item_s1.data == CHAR_MARK) begin
						emit = 1'b1;
						inc_rec = 1'b1;
						clr_kept = 1'b1;
						res_d.kind = K_END;
						res_d.sequence_length = kept_ext[OUT_W-1:0];
					end else begin
						case (act)
							ACT_STRIP: inc_strip = 1'b1;
							ACT_KEEP: begin
								emit = 1'b1;
								inc_kept = 1'b1;
								res_d.kind = K_SEQ;
								res_d.value = item_s1.mapping;
							end
							ACT_FATAL: begin
								emit = 1'b1;
								res_d.kind = K_ERROR;
								res_d.error_code = ERR_ILLEGAL;
								res_d.offending_byte = item_s1.data;
							end
							ACT_NEWLINE: inc_line = 1'b1;
							default: emit = 1'b0;
						endcase
					end
				end
				default: emit = 1'b0;
			endcase
		end
		res_d.line_number    = line_ext[OUT_W-1:0];
		res_d.record_number  = rec_ext[OUT_W-1:0];
		res_d.stripped_total = strip_ext[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_EXPECT;
			line_q  <= COUNT_WIDTH'(1);
			rec_q   <= '0;
			kept_q  <= '0;
			strip_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (inc_line) begin
				line_q <= line_inc;
			end
			if (inc_rec) begin
				rec_q <= rec_inc;
			end
			if (clr_kept) begin
				kept_q <= '0;
			end else if (inc_kept) begin
				kept_q <= kept_inc;
			end
			if (inc_strip) begin
				strip_q <= strip_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res = res_q;

`include "fasta_record_stream_parser_core_assert.svh"

	`FRSP_ASSERT_NEXT(a_halt_sticky, phase_q == PH_HALTED, phase_q == PH_HALTED, "left halted phase")
	`FRSP_ASSERT_NOW(a_line_nonzero, 1'b1, line_q != '0, "line count is zero")
	`FRSP_ASSERT_NOW(a_end_has_record, out_valid_q && res_q.kind == K_END, res_q.record_number != '0 || COUNT_WIDTH > OUT_W, "record end with no record counted")
	`FRSP_ASSERT_NOW(a_err_code, out_valid_q && res_q.kind != K_ERROR, res_q.error_code == ERR_NONE, "error code on a non-error result")
	`FRSP_ASSERT_NEXT(a_kept_cleared, fire && clr_kept, kept_q == '0, "kept length not cleared at record end")

endmodule

`default_nettype wire

### src/fasta_record_stream_parser_core.sv
// Parses a FASTA byte stream and emits header bytes, mapped sequence bytes,
// record ends, errors and end-of-input results. One transaction is accepted
// every clock cycle while results are taken; a waiting result holds the input
// once the input stage is also full. The accepting edge loads the input stage and
// reads the 256-entry action and mapping table; any result is then loaded into the
// result register through the phase logic once that register is free or its
// result is being taken. A table write takes effect for the very
// next byte. The table has no reset and no clearing pass: every entry a byte
// may look up must be written first. Counters are COUNT_WIDTH bits, saturate,
// and are reported as their low 32 bits.
// depends on frsp_pkg, frsp_table and frsp_engine
`default_nettype none

module fasta_record_stream_parser_core
	import frsp_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  data_byte,
	input  wire logic [2:0]  entry_action,
	input  wire logic [7:0]  entry_mapping,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [7:0]       value,
	output logic [1:0]       error_code,
	output logic [7:0]       offending_byte,
	output logic [OUT_W-1:0] line_number,
	output logic [OUT_W-1:0] record_number,
	output logic [OUT_W-1:0] sequence_length,
	output logic [OUT_W-1:0] stripped_total,
	output logic             input_finished
);

	logic       s1_valid_q, accept;
	op_t        op_s1;
	logic [7:0] data_s1;
	logic [2:0] tbl_action;
	logic [7:0] tbl_mapping;
	item_t      item_s1;
	stage_ctl_t ctl;
	res_t       res;

	assign in_ready = ~ctl.s1_valid | ctl.out_free;
	assign accept = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(operation);
			data_s1 <= data_byte;
		end
	end

	frsp_table u_table (
		.clk        (clk),
		.we         (accept && op_t'(operation) == OP_WRITE),
		.waddr      (data_byte),
		.wr_action  (entry_action),
		.wr_mapping (entry_mapping),
		.re         (accept),
		.raddr      (data_byte),
		.rd_action  (tbl_action),
		.rd_mapping (tbl_mapping)
	);

	assign item_s1.op      = op_s1;
	assign item_s1.data    = data_s1;
	assign item_s1.action  = tbl_action;
	assign item_s1.mapping = tbl_mapping;

	frsp_engine #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.s1_valid  (s1_valid_q),
		.out_ready (out_ready),
		.ctl       (ctl),
		.out_valid (out_valid),
		.res       (res)
	);

	assign kind            = res.kind;
	assign value           = res.value;
	assign error_code      = res.error_code;
	assign offending_byte  = res.offending_byte;
	assign line_number     = res.line_number;
	assign record_number   = res.record_number;
	assign sequence_length = res.sequence_length;
	assign stripped_total  = res.stripped_total;
	assign input_finished  = res.input_finished;

endmodule

`default_nettype wire

### tb/fasta_record_stream_parser_core_checker.sv
`timescale 1ns / 100ps
// checker for the fasta record stream parser: tracks parser state from accepted
// input transactions and compares every result transaction in order
// depends on frsp_pkg
module fasta_record_stream_parser_core_checker
	import frsp_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [1:0]       operation,
	input  logic [7:0]       data_byte,
	input  logic [2:0]       entry_action,
	input  logic [7:0]       entry_mapping,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [2:0]       kind,
	input  logic [7:0]       value,
	input  logic [1:0]       error_code,
	input  logic [7:0]       offending_byte,
	input  logic [OUT_W-1:0] line_number,
	input  logic [OUT_W-1:0] record_number,
	input  logic [OUT_W-1:0] sequence_length,
	input  logic [OUT_W-1:0] stripped_total,
	input  logic             input_finished,
	output int               mismatch_count,
	output int               pending_results
);

	phase_t                 parse_phase;
	logic [2:0]             action_of [256];
	logic [7:0]             mapped_of [256];
	logic [COUNT_WIDTH-1:0] lines_seen;
	logic [COUNT_WIDTH-1:0] records_closed;
	logic [COUNT_WIDTH-1:0] kept_in_record;
	logic [COUNT_WIDTH-1:0] strip_total;
	res_t                   expected_results [$];
	res_t                   want;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	task automatic post_result(input kind_t k, input logic [7:0] v, input err_t e,
			input logic [7:0] off, input logic [COUNT_WIDTH-1:0] len, input logic fin);
		res_t r;
		r.kind            = k;
		r.value           = v;
		r.error_code      = e;
		r.offending_byte  = off;
		r.line_number     = OUT_W'(lines_seen);
		r.record_number   = OUT_W'(records_closed);
		r.sequence_length = OUT_W'(len);
		r.stripped_total  = OUT_W'(strip_total);
		r.input_finished  = fin;
		expected_results.push_back(r);
	endtask

	task automatic finish_record(input logic fin);
		logic [COUNT_WIDTH-1:0] len;
		len = kept_in_record;
		records_closed = sat_inc(records_closed);
		kept_in_record = '0;
		post_result(K_END, 8'h00, ERR_NONE, 8'h00, len, fin);
	endtask

	task automatic parse_transaction(input op_t op, input logic [7:0] b, input logic [2:0] a,
			input logic [7:0] m);
		logic [2:0] act;
		case (op)
			OP_WRITE: begin
				action_of[b] = a;
				mapped_of[b] = m;
			end
			OP_END: begin
				case (parse_phase)
					PH_EXPECT, PH_ENDED: begin
						parse_phase = PH_ENDED;
						post_result(K_DONE, 8'h00, ERR_NONE, 8'h00, '0, 1'b0);
					end
					PH_HEADER: begin
						parse_phase = PH_HALTED;
						post_result(K_ERROR, 8'h00, ERR_HDR_OPEN, 8'h00, '0, 1'b0);
					end
					PH_SEQ_START, PH_SEQ_MID: begin
						parse_phase = PH_ENDED;
						finish_record(1'b1);
					end
					default: ;
				endcase
			end
			OP_BYTE: begin
				case (parse_phase)
					PH_EXPECT: begin
						if (b == CHAR_MARK) begin
							parse_phase = PH_HEADER;
						end else begin
							parse_phase = PH_HALTED;
							post_result(K_ERROR, 8'h00, ERR_NO_MARK, 8'h00, '0, 1'b0);
						end
					end
					PH_HEADER: begin
						if (b == CHAR_LF) begin
							lines_seen = sat_inc(lines_seen);
							parse_phase = PH_SEQ_START;
						end else begin
							post_result(K_HEADER, b, ERR_NONE, 8'h00, '0, 1'b0);
						end
					end
					PH_SEQ_START, PH_SEQ_MID: begin
						if (parse_phase == PH_SEQ_START && b == CHAR_MARK) begin
							parse_phase = PH_HEADER;
							finish_record(1'b0);
						end else begin
							parse_phase = (b == CHAR_LF) ? PH_SEQ_START : PH_SEQ_MID;
							act = action_of[b];
							if (act == ACT_STRIP) begin
								strip_total = sat_inc(strip_total);
							end else if (act == ACT_KEEP) begin
								kept_in_record = sat_inc(kept_in_record);
								post_result(K_SEQ, mapped_of[b], ERR_NONE, 8'h00, '0, 1'b0);
							end else if (act == ACT_FATAL) begin
								parse_phase = PH_HALTED;
								post_result(K_ERROR, 8'h00, ERR_ILLEGAL, b, '0, 1'b0);
							end else if (act == ACT_NEWLINE) begin
								lines_seen = sat_inc(lines_seen);
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t mismatch on %s: expected %0h actual %0h", $time, name, exp_val,
				got_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			parse_phase = PH_EXPECT;
			lines_seen = COUNT_WIDTH'(1);
			records_closed = '0;
			kept_in_record = '0;
			strip_total = '0;
			mismatch_count = 0;
			pending_results <= 0;
		end else begin
			if (in_valid && in_ready)
				parse_transaction(op_t'(operation), data_byte, entry_action, entry_mapping);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: expected none actual kind %0d value %0h",
						$time, kind, value);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("value", 32'(want.value), 32'(value));
					check_field("error_code", 32'(want.error_code), 32'(error_code));
					check_field("offending_byte", 32'(want.offending_byte),
						32'(offending_byte));
					check_field("line_number", want.line_number, line_number);
					check_field("record_number", want.record_number, record_number);
					check_field("sequence_length", want.sequence_length, sequence_length);
					check_field("stripped_total", want.stripped_total, stripped_total);
					check_field("input_finished", 32'(want.input_finished),
						32'(input_finished));
				end
			end
			pending_results <= expected_results.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// top of the fasta record stream parser testbench: clock, reset, byte stream
// and table stimulus, handshake pacing and the verdict
// depends on frsp_pkg, fasta_record_stream_parser_core and its checker
module tb;
	import frsp_pkg::*;

	localparam int COUNT_WIDTH = 32;
	localparam int STREAM_ITEMS = 850;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [7:0] BASES [10] = '{"A", "C", "G", "T", "N", "a", "c", "g", "t", "-"};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       operation = OP_NONE;
	logic [7:0]       data_byte = 8'h00;
	logic [2:0]       entry_action = 3'd0;
	logic [7:0]       entry_mapping = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       kind;
	logic [7:0]       value;
	logic [1:0]       error_code;
	logic [7:0]       offending_byte;
	logic [OUT_W-1:0] line_number;
	logic [OUT_W-1:0] record_number;
	logic [OUT_W-1:0] sequence_length;
	logic [OUT_W-1:0] stripped_total;
	logic             input_finished;
	int               mismatch_count;
	int               pending_results;

	int         cycle_count = 0;
	int         items_sent = 0;
	int         send_idle_pct = 8;
	int         recv_stall_pct = 88;
	bit         entry_set [256];
	logic [2:0] entry_act [256];
	bit         line_start = 1'b0;

	fasta_record_stream_parser_core #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .data_byte(data_byte),
		.entry_action(entry_action), .entry_mapping(entry_mapping),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .error_code(error_code),
		.offending_byte(offending_byte), .line_number(line_number),
		.record_number(record_number), .sequence_length(sequence_length),
		.stripped_total(stripped_total), .input_finished(input_finished)
	);

	fasta_record_stream_parser_core_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .data_byte(data_byte),
		.entry_action(entry_action), .entry_mapping(entry_mapping),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .error_code(error_code),
		.offending_byte(offending_byte), .line_number(line_number),
		.record_number(record_number), .sequence_length(sequence_length),
		.stripped_total(stripped_total), .input_finished(input_finished),
		.mismatch_count(mismatch_count), .pending_results(pending_results)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("fasta_record_stream_parser_core test failed");
			$finish;
		end
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [2:0] rand_action();
		return 3'($urandom_range(0, 7));
	endfunction

	task automatic send_item(input op_t op, input logic [7:0] b, input logic [2:0] a,
			input logic [7:0] m);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= b;
		entry_action <= a;
		entry_mapping <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (items_sent < STREAM_ITEMS / 3) begin
			send_idle_pct = 8;
			recv_stall_pct = 88;
		end else if (items_sent < 2 * STREAM_ITEMS / 3) begin
			send_idle_pct = 88;
			recv_stall_pct = 8;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	task automatic load_entry(input logic [7:0] b, input logic [2:0] a, input logic [7:0] m);
		send_item(OP_WRITE, b, a, m);
		entry_set[b] = 1'b1;
		entry_act[b] = a;
	endtask

	function automatic logic [2:0] safe_action();
		logic [2:0] a;
		a = 3'($urandom_range(0, 6));
		if (a >= ACT_FATAL)
			a = a + 3'd1;
		if ($urandom_range(0, 2) == 0)
			a = ACT_KEEP;
		return a;
	endfunction

	// every byte gets a table entry before it is ever sent
	task automatic send_stream(input logic [7:0] b);
		if (!entry_set[b])
			load_entry(b, safe_action(), rand_byte());
		send_item(OP_BYTE, b, rand_action(), rand_byte());
	endtask

	task automatic seq_byte(input logic [7:0] b);
		if (entry_set[b] && entry_act[b] == ACT_FATAL)
			load_entry(b, safe_action(), rand_byte());
		send_stream(b);
		line_start = (b == CHAR_LF);
	endtask

	function automatic logic [7:0] pick_seq_byte();
		int unsigned r;
		logic [7:0]  b;
		r = $urandom_range(0, 99);
		if (r < 12)
			b = CHAR_LF;
		else if (r < 25)
			b = rand_byte();
		else
			b = BASES[$urandom_range(0, 9)];
		if (line_start && b == CHAR_MARK)
			b = "A";
		return b;
	endfunction

	task automatic stir_table();
		if ($urandom_range(0, 3) == 0)
			send_item(OP_NONE, rand_byte(), rand_action(), rand_byte());
		else
			load_entry(rand_byte(), rand_action(), rand_byte());
	endtask

	task automatic header_bytes(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = ($urandom_range(0, 7) == 0) ? CHAR_MARK : rand_byte();
			if (b == CHAR_LF)
				b = 8'h20;
			send_stream(b);
		end
	endtask

	// header content, its line feed, then sequence lines; ends inside the sequence
	task automatic record_body();
		int m;
		header_bytes(int'($urandom_range(0, 8)));
		send_stream(CHAR_LF);
		line_start = 1'b1;
		m = ($urandom_range(0, 9) == 0) ? int'($urandom_range(40, 80))
			: int'($urandom_range(0, 24));
		repeat (m) begin
			if ($urandom_range(0, 99) < 6)
				stir_table();
			seq_byte(pick_seq_byte());
		end
	endtask

	task automatic next_record();
		if (!line_start)
			seq_byte(CHAR_LF);
		send_stream(CHAR_MARK);
		line_start = 1'b0;
	endtask

	task automatic directed_records();
		logic [7:0] seq_list [8];
		seq_list = '{"A", "C", "-", "*", 8'hFF, 8'h00, CHAR_MARK, CHAR_LF};
		send_item(OP_NONE, 8'hFF, 3'd7, 8'hFF);
		load_entry("A", ACT_KEEP, 8'hFF);
		load_entry("C", ACT_KEEP, 8'h00);
		load_entry("-", ACT_STRIP, 8'h2D);
		load_entry("*", ACT_SILENT, 8'h2A);
		load_entry(CHAR_LF, ACT_NEWLINE, 8'h0A);
		load_entry(8'hFF, 3'd7, 8'h00);
		load_entry(8'h00, 3'd5, 8'hFF);
		load_entry(CHAR_MARK, ACT_KEEP, 8'h3C);
		send_stream(CHAR_MARK);
		send_stream(8'h00);
		send_stream(8'hFF);
		send_stream(CHAR_MARK);
		send_stream(CHAR_LF);
		foreach (seq_list[i])
			seq_byte(seq_list[i]);
		// close, empty header, then an empty record
		send_stream(CHAR_MARK);
		send_stream(CHAR_LF);
		send_stream(CHAR_MARK);
		line_start = 1'b0;
	endtask

	task automatic after_stop();
		int unsigned r;
		send_item(OP_END, rand_byte(), rand_action(), rand_byte());
		send_stream(rand_byte());
		repeat (6) begin
			r = $urandom_range(0, 3);
			case (op_t'(r))
				OP_BYTE:  send_stream(rand_byte());
				OP_WRITE: load_entry(rand_byte(), rand_action(), rand_byte());
				default:  send_item(op_t'(r), rand_byte(), rand_action(), rand_byte());
			endcase
		end
	endtask

	task automatic stop_stream();
		logic [7:0] b;
		case ($urandom_range(0, 2))
			0: send_item(OP_END, rand_byte(), rand_action(), rand_byte());
			1: begin
				b = rand_byte();
				if (b == CHAR_MARK)
					b = 8'h21;
				load_entry(b, ACT_FATAL, rand_byte());
				send_stream(b);
			end
			default: begin
				next_record();
				header_bytes(int'($urandom_range(0, 4)));
				send_item(OP_END, rand_byte(), rand_action(), rand_byte());
			end
		endcase
	endtask

	initial begin
		int         mode;
		logic [7:0] b;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		mode = int'($urandom_range(0, 15));
		if (mode == 0) begin
			// stream that does not open with a header marker
			b = rand_byte();
			if (b == CHAR_MARK)
				b = 8'h00;
			send_stream(b);
		end else if (mode == 1) begin
			// input ends before any record
			send_item(OP_END, rand_byte(), rand_action(), rand_byte());
		end else begin
			directed_records();
			record_body();
			while (items_sent < STREAM_ITEMS) begin
				next_record();
				record_body();
			end
			stop_stream();
		end
		after_stop();
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("fasta_record_stream_parser_core test passed");
		else
			$display("fasta_record_stream_parser_core test failed");
		$finish;
	end

endmodule
